// ===== rtl/core/i2cms_pkg.sv =====
// shared types and command codes for the i2c master bit sequencer
package i2cms_pkg;

  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_START     = 3'd1;
  localparam logic [2:0] CMD_STOP      = 3'd2;
  localparam logic [2:0] CMD_WRITE     = 3'd3;
  localparam logic [2:0] CMD_READ_ACK  = 3'd4;
  localparam logic [2:0] CMD_READ_NACK = 3'd5;

  localparam int unsigned TOP_BIT   = 7;
  localparam logic [3:0]  BITS_DONE = 4'd8;

  typedef struct packed {
    logic [2:0]  active_command;
    logic [2:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [15:0] wait_count;
    logic        pin_scl;
    logic        pin_sda;
    logic        pin_drive;
    logic        last_ack;
    logic [7:0]  last_read;
  } seq_state_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driving;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;
  } out_item_t;

endpackage

// ===== rtl/core/i2cms_step.sv =====
// one interval of the pin sequencer: next state and result item
module i2cms_step (
  input  i2cms_pkg::seq_state_t st_cur,
  input  i2cms_pkg::in_item_t   item,
  input  logic [15:0]           ack_wait_limit,
  output i2cms_pkg::seq_state_t st_nxt,
  output i2cms_pkg::out_item_t  res
);
  import i2cms_pkg::*;

  localparam logic [2:0] PH_0 = 3'd0;
  localparam logic [2:0] PH_1 = 3'd1;
  localparam logic [2:0] PH_2 = 3'd2;
  localparam logic [2:0] PH_3 = 3'd3;
  localparam logic [2:0] PH_4 = 3'd4;
  localparam logic [2:0] PH_5 = 3'd5;
  localparam logic [2:0] PH_6 = 3'd6;
  localparam logic [2:0] PH_7 = 3'd7;

  seq_state_t  s;
  logic        busy;
  logic        done;
  logic [3:0]  bit_inc;
  logic [16:0] wait_inc;

  always_comb begin
    s = st_cur;
    done = 1'b0;
    if (s.active_command == CMD_NONE && item.command >= CMD_START &&
        item.command <= CMD_READ_NACK) begin
      s.active_command = item.command;
      s.phase = PH_0;
      s.bit_count = 4'd0;
      s.wait_count = 16'd0;
      s.shift_reg = (item.command == CMD_WRITE) ? item.write_byte : 8'd0;
    end
    busy = (s.active_command != CMD_NONE);
    bit_inc = s.bit_count + 4'd1;
    wait_inc = {1'b0, s.wait_count} + 17'd1;

    case (s.active_command)
      CMD_START: begin
        s.pin_drive = 1'b1;
        case (s.phase)
          PH_0: begin s.pin_sda = 1'b1; s.phase = PH_1; end
          PH_1: begin s.pin_scl = 1'b1; s.phase = PH_2; end
          PH_2: begin s.pin_sda = 1'b0; s.phase = PH_3; end
          default: begin s.pin_scl = 1'b0; done = 1'b1; end
        endcase
      end
      CMD_STOP: begin
        s.pin_drive = 1'b1;
        case (s.phase)
          PH_0: begin s.pin_sda = 1'b0; s.phase = PH_1; end
          PH_1: begin s.pin_scl = 1'b1; s.phase = PH_2; end
          default: begin s.pin_sda = 1'b1; done = 1'b1; end
        endcase
      end
      CMD_WRITE: begin
        case (s.phase)
          PH_0: begin
            s.pin_drive = 1'b1;
            s.pin_sda = s.shift_reg[TOP_BIT];
            s.phase = PH_1;
          end
          PH_1: begin s.pin_scl = 1'b1; s.phase = PH_2; end
          PH_2: begin
            s.pin_scl = 1'b0;
            s.shift_reg = {s.shift_reg[6:0], 1'b0};
            s.bit_count = bit_inc;
            s.phase = (bit_inc >= BITS_DONE) ? PH_3 : PH_0;
          end
          PH_3: begin s.pin_drive = 1'b1; s.pin_sda = 1'b1; s.phase = PH_4; end
          PH_4: begin s.pin_drive = 1'b0; s.phase = PH_5; end
          PH_5: begin s.pin_scl = 1'b1; s.phase = PH_6; end
          PH_6: begin
            if (!item.sda_in) begin
              s.last_ack = 1'b1;
              s.phase = PH_7;
            end else if (wait_inc > {1'b0, ack_wait_limit}) begin
              s.last_ack = 1'b0;
              s.phase = PH_7;
            end else begin
              s.wait_count = wait_inc[15:0];
            end
          end
          default: begin s.pin_scl = 1'b0; done = 1'b1; end
        endcase
      end
      CMD_READ_ACK, CMD_READ_NACK: begin
        case (s.phase)
          PH_0: begin s.pin_drive = 1'b0; s.pin_scl = 1'b1; s.phase = PH_1; end
          PH_1: begin s.shift_reg = {s.shift_reg[6:0], item.sda_in}; s.phase = PH_2; end
          PH_2: begin
            s.pin_scl = 1'b0;
            s.bit_count = bit_inc;
            s.phase = (bit_inc >= BITS_DONE) ? PH_3 : PH_0;
          end
          PH_3: begin
            s.pin_drive = 1'b1;
            s.pin_sda = (s.active_command == CMD_READ_NACK);
            s.phase = PH_4;
          end
          PH_4: begin s.pin_scl = 1'b1; s.phase = PH_5; end
          default: begin
            s.pin_scl = 1'b0;
            s.last_read = s.shift_reg;
            done = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase

    if (done) begin
      s.active_command = CMD_NONE;
      s.phase = PH_0;
      s.bit_count = 4'd0;
    end

    st_nxt = s;
    res.scl_level = s.pin_scl;
    res.sda_level = s.pin_sda;
    res.sda_driving = s.pin_drive;
    res.busy_res = busy;
    res.done_res = done;
    res.ack_received = s.last_ack;
    res.read_byte = s.last_read;
  end

endmodule

// ===== rtl/core/i2c_master_bit_sequencer_unit.sv =====
// top level: input register, sequencer state, step logic and result register
// an accepted item is held in the input register, and its result in the result register
// throughput: one item per cycle while out_ready does not hold a waiting result; the step logic is combinational
// the input and result registers let an item enter while a result waits
// reset (rst_n low, synchronous): sequencer idle, scl and sda latches high,
// sda released, ack_wait_limit back to 100, both register stages empty
module i2c_master_bit_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_write_byte,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_level,
  output logic        out_sda_level,
  output logic        out_sda_driving,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_ack_received,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_ack_wait_limit
);
  import i2cms_pkg::*;

  localparam logic [15:0] LIMIT_RESET = 16'd100;

  logic       in_valid_r;
  in_item_t   in_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  seq_state_t st_r;
  seq_state_t st_nxt;
  out_item_t  res_nxt;
  logic [15:0] limit_r;
  logic       fire;

  assign fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || fire;
  assign cfg_ready = 1'b1;

  i2cms_step u_step (
    .st_cur         (st_r),
    .item           (in_item_r),
    .ack_wait_limit (limit_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r <= LIMIT_RESET;
      st_r <= '{active_command: CMD_NONE, phase: 3'd0, bit_count: 4'd0,
                shift_reg: 8'd0, wait_count: 16'd0, pin_scl: 1'b1,
                pin_sda: 1'b1, pin_drive: 1'b0, last_ack: 1'b0,
                last_read: 8'd0};
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_ack_wait_limit;
      end
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= '{command: in_command, write_byte: in_write_byte, sda_in: in_sda_in};
    end
    if (fire) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_scl_level = out_item_r.scl_level;
  assign out_sda_level = out_item_r.sda_level;
  assign out_sda_driving = out_item_r.sda_driving;
  assign out_busy_res = out_item_r.busy_res;
  assign out_done_res = out_item_r.done_res;
  assign out_ack_received = out_item_r.ack_received;
  assign out_read_byte = out_item_r.read_byte;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.done_res |=> st_r.active_command == CMD_NONE)
    else $error("sequencer not idle after final interval");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("result lost after step");

  a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_count <= BITS_DONE)
    else $error("bit count beyond one byte");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_nxt.done_res |-> res_nxt.busy_res)
    else $error("final interval reported while not busy");

endmodule
